@@ rtl/whf_pkg.sv @@
// ----------------------------------------------------------------------------
// whf_pkg
// Shared constants, register map and controller/datapath types for the
// weighted histogram filler.
// ----------------------------------------------------------------------------
package whf_pkg;

  localparam int MAX_BINS    = 256;
  localparam int COUNT_WIDTH = 32;
  localparam int BIN_IDX_W   = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;

  // divider geometry: 16 bit offset over 16 bit bin width
  localparam int DIV_W      = 16;
  localparam int DIV_CNT_W  = $clog2(DIV_W);
  // common width for index against limit compares
  localparam int CMP_W      = 17;

  localparam int PADDR_W    = 4;
  localparam int PDATA_W    = 32;

  typedef enum logic [1:0] {
    REG_LOW_EDGE  = 2'd0,
    REG_HIGH_EDGE = 2'd1,
    REG_BIN_WIDTH = 2'd2,
    REG_NUM_BINS  = 2'd3
  } whf_reg_e;

  typedef struct packed {
    logic signed [15:0] low_edge;
    logic signed [15:0] high_edge;
    logic [15:0]        bin_width;
    logic [8:0]         num_bins;
  } whf_cfg_t;

  typedef struct packed {
    logic take;
    logic div_step;
    logic reject;
    logic mem_rd;
    logic update;
    logic load_out;
  } whf_cmd_t;

  typedef struct packed {
    logic op_read;
    logic pre_ok;
    logic rb_ok;
    logic idx_ok;
    logic div_last;
    logic out_free;
  } whf_sts_t;

endpackage

@@ rtl/whf_regs.sv @@
// ----------------------------------------------------------------------------
// whf_regs
// APB register file holding the histogram range, bin width and bin count.
// ----------------------------------------------------------------------------
module whf_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [whf_pkg::PADDR_W-1:0]   paddr,
  input  logic [whf_pkg::PDATA_W-1:0]   pwdata,
  output logic [whf_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready,
  output whf_pkg::whf_cfg_t             cfg_o
);

  whf_pkg::whf_cfg_t cfg_q, cfg_d;
  whf_pkg::whf_reg_e reg_sel;
  logic              wr_en;

  assign reg_sel = whf_pkg::whf_reg_e'(paddr[3:2]);
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;
  assign cfg_o   = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (reg_sel)
        whf_pkg::REG_LOW_EDGE:  cfg_d.low_edge  = pwdata[15:0];
        whf_pkg::REG_HIGH_EDGE: cfg_d.high_edge = pwdata[15:0];
        whf_pkg::REG_BIN_WIDTH: cfg_d.bin_width = pwdata[15:0];
        whf_pkg::REG_NUM_BINS:  cfg_d.num_bins  = pwdata[8:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      whf_pkg::REG_LOW_EDGE:  prdata = 32'(unsigned'(cfg_q.low_edge));
      whf_pkg::REG_HIGH_EDGE: prdata = 32'(unsigned'(cfg_q.high_edge));
      whf_pkg::REG_BIN_WIDTH: prdata = 32'(cfg_q.bin_width);
      whf_pkg::REG_NUM_BINS:  prdata = 32'(cfg_q.num_bins);
      default:                prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.low_edge  <= 16'sd0;
      cfg_q.high_edge <= 16'sd32767;
      cfg_q.bin_width <= 16'd128;
      cfg_q.num_bins  <= 9'd256;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

@@ rtl/whf_div.sv @@
// ----------------------------------------------------------------------------
// whf_div
// Restoring divider, one quotient bit per step, for the bin index.
// ----------------------------------------------------------------------------
module whf_div (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         load_i,
  input  logic                         step_i,
  input  logic [whf_pkg::DIV_W-1:0]    dividend_i,
  input  logic [whf_pkg::DIV_W-1:0]    divisor_i,
  output logic [whf_pkg::DIV_W-1:0]    quotient_o,
  output logic                         last_o
);

  logic [whf_pkg::DIV_W:0]       rem_q, rem_d;
  logic [whf_pkg::DIV_W:0]       trial;
  logic [whf_pkg::DIV_W-1:0]     quo_q, quo_d;
  logic [whf_pkg::DIV_CNT_W-1:0] cnt_q, cnt_d;

  assign trial      = {rem_q[whf_pkg::DIV_W-1:0], quo_q[whf_pkg::DIV_W-1]};
  assign quotient_o = quo_q;
  assign last_o     = (cnt_q == whf_pkg::DIV_CNT_W'(whf_pkg::DIV_W - 1));

  always_comb begin
    rem_d = rem_q;
    quo_d = quo_q;
    cnt_d = cnt_q;
    if (load_i) begin
      rem_d = '0;
      quo_d = dividend_i;
      cnt_d = '0;
    end else if (step_i) begin
      cnt_d = cnt_q + 1'b1;
      if (trial >= {1'b0, divisor_i}) begin
        rem_d = trial - {1'b0, divisor_i};
        quo_d = {quo_q[whf_pkg::DIV_W-2:0], 1'b1};
      end else begin
        rem_d = trial;
        quo_d = {quo_q[whf_pkg::DIV_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
  end

endmodule

@@ rtl/whf_dp.sv @@
// ----------------------------------------------------------------------------
// whf_dp
// Datapath: item capture, range check, divider, bin store with
// read-modify-write, result and output registers.
// ----------------------------------------------------------------------------
module whf_dp (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  whf_pkg::whf_cfg_t     cfg_i,
  input  whf_pkg::whf_cmd_t     cmd_i,
  output whf_pkg::whf_sts_t     sts_o,
  input  logic                  op_i,
  input  logic signed [15:0]    sample_i,
  input  logic [15:0]           weight_i,
  input  logic [7:0]            read_bin_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [31:0]           bin_count_o,
  output logic [7:0]            bin_index_o,
  output logic                  accepted_o,
  output logic                  saturated_o
);

  localparam int CW = whf_pkg::COUNT_WIDTH;
  localparam int IW = whf_pkg::BIN_IDX_W;

  function automatic logic [31:0] report(input logic [CW-1:0] c);
    logic [63:0] w;
    w = 64'(c);
    return (w > 64'h0000_0000_FFFF_FFFF) ? 32'hFFFF_FFFF : w[31:0];
  endfunction

  // item capture
  logic                  op_q;
  logic [15:0]           weight_q;
  logic [7:0]            rb_q;
  logic                  pre_ok_q;
  logic [16:0]           offset;
  logic                  in_range;

  // divider
  logic [whf_pkg::DIV_W-1:0] quo;
  logic                      div_last;

  // bin store
  logic [CW-1:0]         mem_q [whf_pkg::MAX_BINS];
  logic [whf_pkg::MAX_BINS-1:0] vld_q;
  logic [CW-1:0]         rdata_q;
  logic                  vld_rd_q;
  logic [IW-1:0]         addr;
  logic [IW-1:0]         idx_q;
  logic [CW-1:0]         old_cnt;
  logic [CW:0]           sum_ext;
  logic [CW-1:0]         sum;
  logic                  wr_en;

  // limit compares
  logic [whf_pkg::CMP_W-1:0] nb_ext;
  logic [whf_pkg::CMP_W-1:0] limit;

  // result and output registers
  logic [31:0]           res_count_q;
  logic [7:0]            res_index_q;
  logic                  res_acc_q;
  logic                  res_sat_q;
  logic                  out_valid_q;
  logic [31:0]           out_count_q;
  logic [7:0]            out_index_q;
  logic                  out_acc_q;
  logic                  out_sat_q;

  assign in_range = (sample_i > cfg_i.low_edge) && (sample_i < cfg_i.high_edge);
  assign offset   = 17'(sample_i) - 17'(cfg_i.low_edge);

  whf_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (cmd_i.take),
    .step_i     (cmd_i.div_step),
    .dividend_i (offset[15:0]),
    .divisor_i  (cfg_i.bin_width),
    .quotient_o (quo),
    .last_o     (div_last)
  );

  assign nb_ext = whf_pkg::CMP_W'(cfg_i.num_bins);
  assign limit  = (nb_ext < whf_pkg::CMP_W'(whf_pkg::MAX_BINS)) ? nb_ext :
                  whf_pkg::CMP_W'(whf_pkg::MAX_BINS);

  assign sts_o.op_read  = op_q;
  assign sts_o.pre_ok   = pre_ok_q;
  assign sts_o.rb_ok    = whf_pkg::CMP_W'(rb_q) < limit;
  assign sts_o.idx_ok   = whf_pkg::CMP_W'(quo) < limit;
  assign sts_o.div_last = div_last;
  assign sts_o.out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      op_q     <= op_i;
      weight_q <= weight_i;
      rb_q     <= read_bin_i;
      pre_ok_q <= in_range && (cfg_i.bin_width != 16'd0);
    end
  end

  // store access
  assign addr    = op_q ? IW'(rb_q) : IW'(quo);
  assign old_cnt = vld_rd_q ? rdata_q : '0;
  assign sum_ext = {1'b0, old_cnt} + (CW+1)'(weight_q);
  assign sum     = sum_ext[CW] ? {CW{1'b1}} : sum_ext[CW-1:0];
  assign wr_en   = cmd_i.update && !op_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.mem_rd) begin
      rdata_q <= mem_q[addr];
      idx_q   <= addr;
    end
    if (wr_en) begin
      mem_q[idx_q] <= sum;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      vld_rd_q <= 1'b0;
    end else begin
      if (cmd_i.mem_rd) begin
        vld_rd_q <= vld_q[addr];
      end
      if (wr_en) begin
        vld_q[idx_q] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.reject) begin
      res_count_q <= '0;
      res_index_q <= op_q ? rb_q : 8'd0;
      res_acc_q   <= 1'b0;
      res_sat_q   <= 1'b0;
    end else if (cmd_i.update) begin
      res_acc_q <= 1'b1;
      if (op_q) begin
        res_count_q <= report(old_cnt);
        res_index_q <= rb_q;
        res_sat_q   <= 1'b0;
      end else begin
        res_count_q <= report(sum);
        res_index_q <= 8'(idx_q);
        res_sat_q   <= (sum == {CW{1'b1}});
      end
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_count_q <= res_count_q;
      out_index_q <= res_index_q;
      out_acc_q   <= res_acc_q;
      out_sat_q   <= res_sat_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign bin_count_o = out_count_q;
  assign bin_index_o = out_index_q;
  assign accepted_o  = out_acc_q;
  assign saturated_o = out_sat_q;

endmodule

@@ rtl/whf_ctrl.sv @@
// ----------------------------------------------------------------------------
// whf_ctrl
// Controller state machine sequencing capture, divide, store access and
// result hand-off.
// ----------------------------------------------------------------------------
module whf_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  whf_pkg::whf_sts_t  sts_i,
  output whf_pkg::whf_cmd_t  cmd_o
);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_DEC   = 6'b000010,
    S_DIV   = 6'b000100,
    S_CHECK = 6'b001000,
    S_RD    = 6'b010000,
    S_UPD   = 6'b100000
  } state_e;

  state_e state_q, state_d;
  logic   done_q, done_d;

  always_comb begin
    state_d    = state_q;
    done_d     = done_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    if (done_q) begin
      // finished result waits for the output register
      if (sts_i.out_free) begin
        cmd_o.load_out = 1'b1;
        done_d         = 1'b0;
      end
    end else begin
      case (state_q)
        S_IDLE: begin
          in_stall_o = 1'b0;
          if (in_valid_i) begin
            cmd_o.take = 1'b1;
            state_d    = S_DEC;
          end
        end
        S_DEC: begin
          if (sts_i.op_read) begin
            if (sts_i.rb_ok) begin
              state_d = S_RD;
            end else begin
              cmd_o.reject = 1'b1;
              done_d       = 1'b1;
              state_d      = S_IDLE;
            end
          end else if (sts_i.pre_ok) begin
            state_d = S_DIV;
          end else begin
            cmd_o.reject = 1'b1;
            done_d       = 1'b1;
            state_d      = S_IDLE;
          end
        end
        S_DIV: begin
          cmd_o.div_step = 1'b1;
          if (sts_i.div_last) begin
            state_d = S_CHECK;
          end
        end
        S_CHECK: begin
          if (sts_i.idx_ok) begin
            state_d = S_RD;
          end else begin
            cmd_o.reject = 1'b1;
            done_d       = 1'b1;
            state_d      = S_IDLE;
          end
        end
        S_RD: begin
          cmd_o.mem_rd = 1'b1;
          state_d      = S_UPD;
        end
        S_UPD: begin
          cmd_o.update = 1'b1;
          done_d       = 1'b1;
          state_d      = S_IDLE;
        end
        default: begin
          state_d = S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

endmodule

@@ rtl/weighted_histogram_filler_core.sv @@
// ----------------------------------------------------------------------------
// weighted_histogram_filler_core
// Fixed-width weighted histogram with a 256-bin saturating counter store.
// ----------------------------------------------------------------------------
// One item is worked on at a time, with a one-deep output register so a new
// item is taken while the previous result still waits. A fill inside the
// range passes from transfer to result through capture, decode, a 16-step
// restoring divider for the bin index (one quotient bit per cycle), a limit
// check, a store read and a write-back. A read skips divider and check; a fill
// outside the range, with zero bin width, or an out-of-range read ends at
// decode, an index past the bins in use at the limit check. The store is
// cleared by per-bin valid flags at reset, so items are taken right after
// reset. Registers sit on the APB port: low_edge at 0x0, high_edge at 0x4,
// bin_width at 0x8, num_bins at 0xC; write them only while the block is idle.
// ----------------------------------------------------------------------------
module weighted_histogram_filler_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          op_i,
  input  logic signed [15:0]            sample_i,
  input  logic [15:0]                   weight_i,
  input  logic [7:0]                    read_bin_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [31:0]                   bin_count_o,
  output logic [7:0]                    bin_index_o,
  output logic                          accepted_o,
  output logic                          saturated_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [whf_pkg::PADDR_W-1:0]   paddr,
  input  logic [whf_pkg::PDATA_W-1:0]   pwdata,
  output logic [whf_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready
);

  whf_pkg::whf_cfg_t cfg;
  whf_pkg::whf_cmd_t cmd;
  whf_pkg::whf_sts_t sts;

  whf_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  whf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  whf_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .op_i        (op_i),
    .sample_i    (sample_i),
    .weight_i    (weight_i),
    .read_bin_i  (read_bin_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .bin_count_o (bin_count_o),
    .bin_index_o (bin_index_o),
    .accepted_o  (accepted_o),
    .saturated_o (saturated_o)
  );

endmodule

@@ bench/whf_tb_pkg.sv @@
// ----------------------------------------------------------------------------
// whf_tb_pkg
// Item codes shared by the stimulus and the checker of the weighted histogram
// filler bench.
// ----------------------------------------------------------------------------
package whf_tb_pkg;

  localparam logic OP_FILL = 1'b0;
  localparam logic OP_READ = 1'b1;

endpackage

@@ bench/whf_checker.sv @@
// ----------------------------------------------------------------------------
// whf_checker
// Watches the item, result and register channels of the histogram filler,
// keeps its own copy of the registers and the bin store, predicts the result
// of every accepted item and compares each result transfer field by field
// with the oldest prediction. Hands the failure and pending counts upward.
// ----------------------------------------------------------------------------
module whf_checker (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  input  logic                        in_stall_i,
  input  logic                        op_i,
  input  logic signed [15:0]          sample_i,
  input  logic [15:0]                 weight_i,
  input  logic [7:0]                  read_bin_i,
  input  logic                        out_valid_i,
  input  logic                        out_stall_i,
  input  logic [31:0]                 bin_count_i,
  input  logic [7:0]                  bin_index_i,
  input  logic                        accepted_i,
  input  logic                        saturated_i,
  input  logic                        psel_i,
  input  logic                        penable_i,
  input  logic                        pwrite_i,
  input  logic [whf_pkg::PADDR_W-1:0] paddr_i,
  input  logic [whf_pkg::PDATA_W-1:0] pwdata_i,
  input  logic                        pready_i,
  output int                          errors_o,
  output int                          pending_o
);
  import whf_pkg::*;
  import whf_tb_pkg::*;

  typedef struct packed {
    logic [31:0] count;
    logic [7:0]  index;
    logic        accepted;
    logic        saturated;
  } bin_result_t;

  logic signed [15:0] cfg_low;
  logic signed [15:0] cfg_high;
  logic [15:0]        cfg_width;
  logic [8:0]         cfg_nbins;
  logic [31:0]        bin_store [MAX_BINS];
  bin_result_t        expected_q [$];
  bin_result_t        seen;
  bin_result_t        want;
  int                 fail_cnt;
  whf_reg_e           reg_sel;

  function automatic bin_result_t predict_bin(input logic op, input logic signed [15:0] smp,
                                              input logic [15:0] wt, input logic [7:0] rb);
    bin_result_t r;
    int unsigned lim;
    int          offs;
    int unsigned idx;
    logic [32:0] sum;
    r = '0;
    lim = (cfg_nbins < 9'd256) ? int'(cfg_nbins) : 256;
    if (op == OP_READ) begin
      r.index = rb;
      if (rb < lim) begin
        r.count = bin_store[rb];
        r.accepted = 1'b1;
      end
      return r;
    end
    if (!(smp > cfg_low && smp < cfg_high) || cfg_width == 16'd0) return r;
    offs = int'(smp) - int'(cfg_low);
    idx = offs / int'(cfg_width);
    if (idx >= lim) return r;
    sum = {1'b0, bin_store[idx]} + 33'(wt);
    if (sum[32]) sum = 33'h0_FFFF_FFFF;
    bin_store[idx] = sum[31:0];
    r.count = sum[31:0];
    r.index = idx[7:0];
    r.accepted = 1'b1;
    r.saturated = &sum[31:0];
    return r;
  endfunction

  task automatic check_field(input string fname, input logic [31:0] want_v,
                             input logic [31:0] got_v);
    if (want_v !== got_v) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, fname, want_v, got_v);
      fail_cnt++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_low = 16'sd0;
      cfg_high = 16'sd32767;
      cfg_width = 16'd128;
      cfg_nbins = 9'd256;
      foreach (bin_store[i]) bin_store[i] = '0;
      expected_q.delete();
      fail_cnt = 0;
      errors_o <= 0;
      pending_o <= 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        seen = '{bin_count_i, bin_index_i, accepted_i, saturated_i};
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %0h", $time, seen);
          fail_cnt++;
        end else begin
          want = expected_q.pop_front();
          check_field("bin_count", want.count, seen.count);
          check_field("bin_index", 32'(want.index), 32'(seen.index));
          check_field("accepted", 32'(want.accepted), 32'(seen.accepted));
          check_field("saturated", 32'(want.saturated), 32'(seen.saturated));
        end
      end
      if (in_valid_i && !in_stall_i)
        expected_q.push_back(predict_bin(op_i, sample_i, weight_i, read_bin_i));
      if (psel_i && penable_i && pwrite_i && pready_i) begin
        reg_sel = whf_reg_e'(paddr_i[3:2]);
        case (reg_sel)
          REG_LOW_EDGE: begin
            cfg_low = pwdata_i[15:0];
          end
          REG_HIGH_EDGE: begin
            cfg_high = pwdata_i[15:0];
          end
          REG_BIN_WIDTH: begin
            cfg_width = pwdata_i[15:0];
          end
          REG_NUM_BINS: begin
            cfg_nbins = pwdata_i[8:0];
          end
          default: begin
          end
        endcase
      end
      errors_o <= fail_cnt;
      pending_o <= expected_q.size();
    end
  end

endmodule

@@ bench/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Bench for the weighted histogram filler. Drives directed items for the
// range edges, zero width, zero and oversized bin counts and a few full-weight
// fills into one bin, then random items over several random register settings
// with random gaps and stalls on both sides. The checker beside the block
// predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_top;
  import whf_pkg::*;
  import whf_tb_pkg::*;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 in_valid_i = 1'b0;
  logic                 in_stall_o;
  logic                 op_i = OP_FILL;
  logic signed [15:0]   sample_i = '0;
  logic [15:0]          weight_i = '0;
  logic [7:0]           read_bin_i = '0;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  logic [31:0]          bin_count_o;
  logic [7:0]           bin_index_o;
  logic                 accepted_o;
  logic                 saturated_o;
  logic                 psel = 1'b0;
  logic                 penable = 1'b0;
  logic                 pwrite = 1'b0;
  logic [PADDR_W-1:0]   paddr = '0;
  logic [PDATA_W-1:0]   pwdata = '0;
  logic [PDATA_W-1:0]   prdata;
  logic                 pready;
  int                   errors;
  int                   pending;
  bit                   idle_on = 1'b1;
  int                   cur_low = 0;
  int                   cur_width = 128;
  int                   cur_nbins = 256;

  always #4 clk_i = ~clk_i;

  weighted_histogram_filler_core uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .op_i       (op_i),
    .sample_i   (sample_i),
    .weight_i   (weight_i),
    .read_bin_i (read_bin_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .bin_count_o(bin_count_o),
    .bin_index_o(bin_index_o),
    .accepted_o (accepted_o),
    .saturated_o(saturated_o),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  whf_checker u_checker (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_i (in_stall_o),
    .op_i       (op_i),
    .sample_i   (sample_i),
    .weight_i   (weight_i),
    .read_bin_i (read_bin_i),
    .out_valid_i(out_valid_o),
    .out_stall_i(out_stall_i),
    .bin_count_i(bin_count_o),
    .bin_index_i(bin_index_o),
    .accepted_i (accepted_o),
    .saturated_i(saturated_o),
    .psel_i     (psel),
    .penable_i  (penable),
    .pwrite_i   (pwrite),
    .paddr_i    (paddr),
    .pwdata_i   (pwdata),
    .pready_i   (pready),
    .errors_o   (errors),
    .pending_o  (pending)
  );

  task automatic send_item(input logic op, input logic signed [15:0] smp,
                           input logic [15:0] wt, input logic [7:0] rb);
    int gap;
    gap = idle_on ? $urandom_range(9) : 0;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    op_i <= op;
    sample_i <= smp;
    weight_i <= wt;
    read_bin_i <= rb;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (30) @(posedge clk_i);
  endtask

  task automatic write_reg(input whf_reg_e r, input logic [31:0] v);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= {r, 2'b00};
    pwdata <= v;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
  endtask

  task automatic set_config(input int lo, input int hi, input int wd, input int nb);
    wait_idle();
    write_reg(REG_LOW_EDGE, 32'(lo));
    write_reg(REG_HIGH_EDGE, 32'(hi));
    write_reg(REG_BIN_WIDTH, 32'(wd));
    write_reg(REG_NUM_BINS, 32'(nb));
    psel <= 1'b0;
    penable <= 1'b0;
    cur_low = lo;
    cur_width = wd;
    cur_nbins = nb;
  endtask

  // result side: random stall before each result transfer
  initial begin
    int n;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      n = idle_on ? $urandom_range(9) : 0;
      if (n != 0) begin
        out_stall_i <= 1'b1;
        repeat (n) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      @(posedge clk_i);
      while (!out_valid_o) @(posedge clk_i);
    end
  end

  initial begin
    #2_000_000;
    $display("status: fail");
    $finish;
  end

  initial begin
    int lo_v, hi_v, wd_v, nb_v, lim, bin_sel, s_v;
    logic [15:0] wt_v;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // register values after reset
    send_item(OP_READ, 16'sd0, 16'd0, 8'd0);
    send_item(OP_READ, 16'sd0, 16'd0, 8'd255);
    send_item(OP_FILL, 16'sd0, 16'd5, 8'd0);
    send_item(OP_FILL, 16'sd32767, 16'd5, 8'd0);
    send_item(OP_FILL, -16'sd32768, 16'hFFFF, 8'd0);
    send_item(OP_FILL, 16'sd1, 16'hFFFF, 8'hFF);
    send_item(OP_FILL, 16'sd32766, 16'd0, 8'd0);
    send_item(OP_FILL, 16'sd127, 16'd1, 8'd0);
    send_item(OP_READ, 16'sd0, 16'd0, 8'd0);

    // unit width over the full range, more bins than the store holds
    set_config(-32768, 32767, 1, 511);
    send_item(OP_FILL, -16'sd32767, 16'd3, 8'd0);
    send_item(OP_FILL, 16'sd0, 16'd3, 8'd0);
    send_item(OP_FILL, -16'sd32512, 16'd3, 8'd0);
    send_item(OP_FILL, -16'sd32513, 16'd3, 8'd0);
    send_item(OP_READ, 16'sd0, 16'd0, 8'd255);

    set_config(-32768, 32767, 0, 256);
    send_item(OP_FILL, 16'sd100, 16'd7, 8'd0);

    set_config(-32768, 32767, 65535, 1);
    send_item(OP_FILL, 16'sd32766, 16'd9, 8'd0);
    send_item(OP_READ, 16'sd0, 16'd0, 8'd1);
    send_item(OP_READ, 16'sd0, 16'd0, 8'd0);

    set_config(-32768, 32767, 65535, 0);
    send_item(OP_READ, 16'sd0, 16'd0, 8'd0);
    send_item(OP_FILL, 16'sd32766, 16'd9, 8'd0);

    // low edge above high edge
    set_config(100, -100, 1, 256);
    send_item(OP_FILL, 16'sd0, 16'd1, 8'd0);

    // a few full-weight fills into one bin
    set_config(0, 32767, 128, 256);
    idle_on = 1'b0;
    repeat (8) send_item(OP_FILL, 16'sd300, 16'hFFFF, 8'd0);
    send_item(OP_FILL, 16'sd300, 16'd0, 8'd0);
    send_item(OP_READ, 16'sd0, 16'd0, 8'd2);

    for (int phase = 0; phase < 6; phase++) begin
      case ($urandom_range(3))
        0: lo_v = -32768;
        1: lo_v = int'($urandom_range(65535)) - 32768;
        default: lo_v = int'($urandom_range(8191)) - 4096;
      endcase
      case ($urandom_range(3))
        0: hi_v = 32767;
        1: hi_v = int'($urandom_range(65535)) - 32768;
        default: begin
          hi_v = lo_v + int'($urandom_range(40000));
          if (hi_v > 32767) hi_v = 32767;
        end
      endcase
      case ($urandom_range(7))
        0: wd_v = 1;
        1: wd_v = 65535;
        2: wd_v = 0;
        default: wd_v = $urandom_range(600, 1);
      endcase
      case ($urandom_range(7))
        0: nb_v = 1;
        1: nb_v = 256;
        2: nb_v = 0;
        3: nb_v = $urandom_range(511, 257);
        default: nb_v = $urandom_range(256, 1);
      endcase
      set_config(lo_v, hi_v, wd_v, nb_v);
      idle_on = (phase % 3 != 2);
      lim = (cur_nbins < 256) ? cur_nbins : 256;
      repeat (100) begin
        if ($urandom_range(3) == 0) begin
          if ($urandom_range(1) == 1 && lim > 0)
            send_item(OP_READ, 16'(int'($urandom_range(65535))), 16'(int'($urandom_range(65535))),
                      8'($urandom_range(lim - 1)));
          else
            send_item(OP_READ, 16'(int'($urandom_range(65535))), 16'(int'($urandom_range(65535))),
                      8'($urandom_range(255)));
        end else begin
          s_v = int'($urandom_range(65535)) - 32768;
          if (cur_width != 0 && $urandom_range(3) != 0) begin
            bin_sel = int'($urandom_range(lim));
            s_v = cur_low + bin_sel * cur_width + int'($urandom_range(cur_width - 1));
            if (s_v < -32768 || s_v > 32767) s_v = int'($urandom_range(65535)) - 32768;
          end
          if ($urandom_range(3) == 0) wt_v = ($urandom_range(1) == 1) ? 16'hFFFF : 16'h0000;
          else wt_v = 16'($urandom_range(65535));
          send_item(OP_FILL, 16'(s_v), wt_v, 8'($urandom_range(255)));
        end
      end
    end

    idle_on = 1'b1;
    wait_idle();
    if (errors == 0 && pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/whf_pkg.sv
rtl/whf_regs.sv
rtl/whf_div.sv
rtl/whf_dp.sv
rtl/whf_ctrl.sv
rtl/weighted_histogram_filler_core.sv
bench/whf_tb_pkg.sv
bench/whf_checker.sv
bench/tb_top.sv
